[hdl/tlc_pkg.sv]
`default_nettype none
package tlc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOUTH_GREEN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEST_GREEN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_YELLOW      = 2'd2;

   localparam logic [6:0] SOUTH_GREEN_RESET = 7'd12;
   localparam logic [6:0] WEST_GREEN_RESET  = 7'd20;
   localparam logic [3:0] YELLOW_RESET      = 4'd3;

   localparam logic [5:0] LAMPS_SOUTH_GREEN  = 6'h21;
   localparam logic [5:0] LAMPS_SOUTH_YELLOW = 6'h11;
   localparam logic [5:0] LAMPS_WEST_GREEN   = 6'h0C;
   localparam logic [5:0] LAMPS_WEST_YELLOW  = 6'h0A;

   localparam logic [6:0] COUNT_MAX   = 7'd99;
   localparam logic [6:0] SECONDS_MAX = 7'd127;

   typedef enum logic [2:0] {
      PH_SOUTH_GREEN  = 3'd0,
      PH_SOUTH_YELLOW = 3'd1,
      PH_WEST_GREEN   = 3'd2,
      PH_WEST_YELLOW  = 3'd3,
      PH_MAN_GREEN    = 3'd4,
      PH_MAN_YELLOW   = 3'd5,
      PH_ENTRY        = 3'd7
   } phase_type;

   typedef struct packed {
      logic manual_switch;
      logic street_select;
      logic second_tick;
   } req_type;

   typedef struct packed {
      logic [5:0] lamp_pattern;
      logic [3:0] west_tens;
      logic [3:0] west_ones;
      logic [3:0] south_tens;
      logic [3:0] south_ones;
   } rsp_type;

   typedef struct packed {
      logic [6:0] south_green_secs;
      logic [6:0] west_green_secs;
      logic [3:0] yellow_secs;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [6:0] phase_seconds;
      logic [6:0] west_count;
      logic [6:0] south_count;
      logic       manual_street;
   } ctx_type;

   function automatic logic [6:0] sat99(input logic [7:0] v);
      sat99 = (v > 8'(COUNT_MAX)) ? COUNT_MAX : v[6:0];
   endfunction

   function automatic logic [6:0] at_least_one(input logic [6:0] v);
      at_least_one = (v == 7'd0) ? 7'd1 : v;
   endfunction

   // tens digit of a value 0..99 by independent threshold compares
   function automatic logic [3:0] bcd_tens(input logic [6:0] v);
      logic [3:0] t;
      t = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (v >= 7'(10 * k)) t = t + 4'd1;
      end
      bcd_tens = t;
   endfunction

   function automatic logic [3:0] bcd_ones(input logic [6:0] v, input logic [3:0] tens);
      logic [6:0] r;
      r = v - 7'(7'(tens) * 7'd10);
      bcd_ones = r[3:0];
   endfunction

endpackage
`default_nettype wire

[hdl/tlc_step.sv]
`default_nettype none
module tlc_step import tlc_pkg::*; (
   input  wire ctx_type ctx,
   input  wire cfg_type cfg,
   input  wire req_type req,
   output ctx_type      ctx_next,
   output rsp_type      rsp
);

   logic [6:0] len_sg, len_wg, len_y;
   logic [6:0] ld_sg_w, ld_sg_s, ld_wg_w, ld_wg_s, ld_y;
   logic [6:0] secs_inc, west_dec, south_dec;
   logic [6:0] cur_len;
   logic       do_load;
   phase_type  load_ph;
   logic [6:0] wshow, sshow;
   logic [3:0] w_tens, s_tens;

   assign len_sg  = at_least_one(cfg.south_green_secs);
   assign len_wg  = at_least_one(cfg.west_green_secs);
   assign len_y   = at_least_one(7'(cfg.yellow_secs));
   assign ld_sg_w = sat99(8'(cfg.south_green_secs) + 8'(cfg.yellow_secs));
   assign ld_sg_s = sat99(8'(cfg.south_green_secs));
   assign ld_wg_w = sat99(8'(cfg.west_green_secs));
   assign ld_wg_s = sat99(8'(cfg.west_green_secs) + 8'(cfg.yellow_secs));
   assign ld_y    = sat99(8'(cfg.yellow_secs));

   // one elapsed second: counts stop at zero, phase time saturates
   assign secs_inc  = (ctx.phase_seconds < SECONDS_MAX) ? ctx.phase_seconds + 7'd1
                                                        : ctx.phase_seconds;
   assign west_dec  = (ctx.west_count != 7'd0) ? ctx.west_count - 7'd1 : 7'd0;
   assign south_dec = (ctx.south_count != 7'd0) ? ctx.south_count - 7'd1 : 7'd0;

   always_comb begin
      unique case (ctx.phase)
         PH_SOUTH_GREEN: cur_len = len_sg;
         PH_WEST_GREEN:  cur_len = len_wg;
         default:        cur_len = len_y;
      endcase
   end

   // next state
   always_comb begin
      ctx_next = ctx;
      do_load  = 1'b0;
      load_ph  = PH_SOUTH_GREEN;
      if (!req.manual_switch) begin
         unique case (ctx.phase)
            PH_SOUTH_GREEN, PH_SOUTH_YELLOW, PH_WEST_GREEN, PH_WEST_YELLOW: begin
               if (req.second_tick) begin
                  ctx_next.phase_seconds = secs_inc;
                  ctx_next.west_count    = west_dec;
                  ctx_next.south_count   = south_dec;
                  if (secs_inc >= cur_len) begin
                     do_load = 1'b1;
                     unique case (ctx.phase)
                        PH_SOUTH_GREEN:  load_ph = PH_SOUTH_YELLOW;
                        PH_SOUTH_YELLOW: load_ph = PH_WEST_GREEN;
                        PH_WEST_GREEN:   load_ph = PH_WEST_YELLOW;
                        default:         load_ph = PH_SOUTH_GREEN;
                     endcase
                  end
               end
            end
            default: begin
               do_load = 1'b1;
               load_ph = PH_SOUTH_GREEN;
            end
         endcase
      end else begin
         unique case (ctx.phase)
            PH_MAN_GREEN: begin
               if (req.street_select != ctx.manual_street) begin
                  ctx_next.phase         = PH_MAN_YELLOW;
                  ctx_next.phase_seconds = 7'd0;
                  ctx_next.west_count    = ld_y;
                  ctx_next.south_count   = ld_y;
               end
            end
            PH_MAN_YELLOW: begin
               if (req.second_tick) begin
                  ctx_next.phase_seconds = secs_inc;
                  ctx_next.west_count    = west_dec;
                  ctx_next.south_count   = south_dec;
                  if (secs_inc >= len_y) begin
                     ctx_next.phase         = PH_MAN_GREEN;
                     ctx_next.phase_seconds = 7'd0;
                     ctx_next.manual_street = req.street_select;
                     ctx_next.west_count    = 7'd0;
                     ctx_next.south_count   = 7'd0;
                  end
               end
            end
            default: begin
               ctx_next.phase         = PH_MAN_GREEN;
               ctx_next.phase_seconds = 7'd0;
               ctx_next.manual_street = req.street_select;
               ctx_next.west_count    = 7'd0;
               ctx_next.south_count   = 7'd0;
            end
         endcase
      end
      if (do_load) begin
         ctx_next.phase         = load_ph;
         ctx_next.phase_seconds = 7'd0;
         unique case (load_ph)
            PH_SOUTH_GREEN: begin
               ctx_next.west_count  = ld_sg_w;
               ctx_next.south_count = ld_sg_s;
            end
            PH_SOUTH_YELLOW: ctx_next.south_count = ld_y;
            PH_WEST_GREEN: begin
               ctx_next.west_count  = ld_wg_w;
               ctx_next.south_count = ld_wg_s;
            end
            default: ctx_next.west_count = ld_y;
         endcase
      end
   end

   // outputs from the updated state
   always_comb begin
      wshow = ctx_next.west_count;
      sshow = ctx_next.south_count;
      unique case (ctx_next.phase)
         PH_SOUTH_GREEN:  rsp.lamp_pattern = LAMPS_SOUTH_GREEN;
         PH_SOUTH_YELLOW: rsp.lamp_pattern = LAMPS_SOUTH_YELLOW;
         PH_WEST_GREEN:   rsp.lamp_pattern = LAMPS_WEST_GREEN;
         PH_WEST_YELLOW:  rsp.lamp_pattern = LAMPS_WEST_YELLOW;
         PH_MAN_GREEN: begin
            rsp.lamp_pattern = ctx_next.manual_street ? LAMPS_SOUTH_GREEN
                                                      : LAMPS_WEST_GREEN;
            wshow = 7'd0;
            sshow = 7'd0;
         end
         default: rsp.lamp_pattern = ctx_next.manual_street ? LAMPS_SOUTH_YELLOW
                                                             : LAMPS_WEST_YELLOW;
      endcase
      w_tens         = bcd_tens(wshow);
      s_tens         = bcd_tens(sshow);
      rsp.west_tens  = w_tens;
      rsp.west_ones  = bcd_ones(wshow, w_tens);
      rsp.south_tens = s_tens;
      rsp.south_ones = bcd_ones(sshow, s_tens);
   end

endmodule
`default_nettype wire

[hdl/traffic_light_controller.sv]
`default_nettype none
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_data  (manual_switch, street_select, second_tick)
// rsp      out        rsp_valid/rsp_ready  rsp_data  (lamp_pattern, west/south BCD digits)
// csr      in         csr_we               csr_index, csr_wdata (write only)
//
// One request per clock while req_ready is high; its response is registered.
// The phase state, the two countdowns and the BCD digits come from one pass of
// combinational logic between the state registers and the response register.
// A two-entry response stage (output register plus skid) lets one more request
// be taken while a response waits; req_ready drops only when both are full.
// Synchronous reset: entry phase, counts zero, registers to 12/20/3, no response held.
module traffic_light_controller import tlc_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output rsp_type                rsp_data,
   input  wire                    csr_we,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type cfg_ff;
   ctx_type ctx_ff, ctx_in;
   rsp_type step_rsp;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   logic accept;
   logic out_free;

   // hold new requests only while both response slots are occupied
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   tlc_step u_step (
      .ctx      (ctx_ff),
      .cfg      (cfg_ff),
      .req      (req_data),
      .ctx_next (ctx_in),
      .rsp      (step_rsp)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.south_green_secs <= SOUTH_GREEN_RESET;
         cfg_ff.west_green_secs  <= WEST_GREEN_RESET;
         cfg_ff.yellow_secs      <= YELLOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOUTH_GREEN: cfg_ff.south_green_secs <= csr_wdata;
            CSR_WEST_GREEN:  cfg_ff.west_green_secs  <= csr_wdata;
            CSR_YELLOW:      cfg_ff.yellow_secs      <= csr_wdata[3:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // advance the controller state on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.phase         <= PH_ENTRY;
         ctx_ff.phase_seconds <= 7'd0;
         ctx_ff.west_count    <= 7'd0;
         ctx_ff.south_count   <= 7'd0;
         ctx_ff.manual_street <= 1'b0;
      end else if (accept) begin
         ctx_ff <= ctx_in;
      end
   end

   // response stage: fill the output register first, park in skid when stalled
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         rsp_valid_in  = skid_valid_ff || accept;
         rsp_data_in   = skid_valid_ff ? skid_data_ff : step_rsp;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in  = 1'b1;
         skid_valid_in = skid_valid_ff || accept;
         if (!skid_valid_ff) skid_data_in = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
